[sv/tfcw_pkg.sv]
// ----------------------------------------------------------------------------
// tfcw_pkg
// Shared types, constants and the CRC-32 byte update for the transport framer.
// ----------------------------------------------------------------------------
package tfcw_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEN_W     = 24;
  localparam int unsigned TOTAL_W   = LEN_W + 1;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned CRC_W     = 32;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned IDX_W     = 3;

  localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = TOTAL_W'(12);
  localparam logic [IDX_W-1:0]   HDR_LAST_IDX   = IDX_W'(7);
  localparam logic [IDX_W-1:0]   CRC_LAST_IDX   = IDX_W'(4 - 1);
  localparam logic [CRC_W-1:0]   CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY       = 32'hEDB8_8320;

  // one queued item with its frame context
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               opens;
    logic               closes;
    logic [TOTAL_W-1:0] len_total;
    logic [SEQ_W-1:0]   seq;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_HDR,
    ST_DATA,
    ST_CRC
  } back_state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_HDR,
    SRC_CRC
  } byte_src_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/tfcw_front.sv]
// ----------------------------------------------------------------------------
// tfcw_front
// Accepts payload bytes, tracks frame boundaries and the sequence number.
// ----------------------------------------------------------------------------
module tfcw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic [23:0]                in_payload_length,
  output logic                       q_push,
  output tfcw_pkg::q_entry_t         q_wdata,
  input  logic                       q_full
);
  import tfcw_pkg::*;

  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic             opens;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] rem_after;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    opens     = (rem_r == '0);
    // a zero length counts as a single byte
    len_eff   = (in_payload_length == '0) ? LEN_W'(1) : in_payload_length;
    rem_after = (opens ? len_eff : rem_r) - LEN_W'(1);

    q_wdata.data      = in_data_byte;
    q_wdata.opens     = opens;
    q_wdata.closes    = (rem_after == '0);
    q_wdata.len_total = {1'b0, len_eff} + FRAME_OVERHEAD;
    q_wdata.seq       = seq_r;

    rem_nxt = rem_r;
    seq_nxt = seq_r;
    if (q_push) begin
      rem_nxt = rem_after;
      if (rem_after == '0) begin
        seq_nxt = seq_r + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      seq_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      seq_r <= seq_nxt;
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");
  a_seq_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.closes) |=> (seq_r == $past(seq_r) + SEQ_W'(1)))
    else $error("sequence number did not advance on frame close");
  a_open_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.opens) |-> (rem_r == '0))
    else $error("frame opened while one is open");

endmodule

[sv/tfcw_fifo.sv]
// ----------------------------------------------------------------------------
// tfcw_fifo
// Short queue of classified items between the front and the serializer.
// ----------------------------------------------------------------------------
module tfcw_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tfcw_pkg::q_entry_t         wdata,
  output logic                       full,
  input  logic                       pop,
  output logic                       not_empty,
  output tfcw_pkg::q_entry_t         rdata
);
  import tfcw_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r)) else $error("pointers apart on empty");

endmodule

[sv/tfcw_back.sv]
// ----------------------------------------------------------------------------
// tfcw_back
// Serializer: header, payload and CRC trailer bytes into the output register.
// ----------------------------------------------------------------------------
module tfcw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  tfcw_pkg::q_entry_t         q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_run_last,
  output logic                       out_frame_end
);
  import tfcw_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r;
  logic             orl_r;
  logic             ofe_r;

  logic             step;
  byte_src_t        src;
  logic             crc_start;
  logic             is_last;
  logic             is_end;
  logic [7:0]       sel_byte;
  logic [CRC_W-1:0] crc_inv;
  logic [63:0]      hdr_word;

  assign step = q_not_empty && (!ov_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (step) begin
      case (state_r)
        ST_FIRST: begin
          if (q_rdata.opens) begin
            state_nxt = ST_HDR;
            idx_nxt   = IDX_W'(1);
          end else if (q_rdata.closes) begin
            state_nxt = ST_CRC;
            idx_nxt   = '0;
          end
        end
        ST_HDR: begin
          if (idx_r == HDR_LAST_IDX) begin
            state_nxt = ST_DATA;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        ST_DATA: begin
          state_nxt = q_rdata.closes ? ST_CRC : ST_FIRST;
          idx_nxt   = '0;
        end
        ST_CRC: begin
          if (idx_r == CRC_LAST_IDX) begin
            state_nxt = ST_FIRST;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        default: begin
          state_nxt = ST_FIRST;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  // outputs of the sequencer
  always_comb begin
    src       = SRC_DATA;
    crc_start = 1'b0;
    is_last   = 1'b0;
    is_end    = 1'b0;
    case (state_r)
      ST_FIRST: begin
        if (q_rdata.opens) begin
          src       = SRC_HDR;
          crc_start = 1'b1;
        end else begin
          is_last = !q_rdata.closes;
        end
      end
      ST_HDR: begin
        src = SRC_HDR;
      end
      ST_DATA: begin
        is_last = !q_rdata.closes;
      end
      ST_CRC: begin
        src     = SRC_CRC;
        is_last = (idx_r == CRC_LAST_IDX);
        is_end  = (idx_r == CRC_LAST_IDX);
      end
      default: begin
        src = SRC_DATA;
      end
    endcase
  end

  always_comb begin
    hdr_word = {q_rdata.seq, {(32-TOTAL_W){1'b0}}, q_rdata.len_total};
    crc_inv  = ~crc_r;
    case (src)
      SRC_HDR:  sel_byte = hdr_word[{idx_r, 3'b000} +: 8];
      SRC_CRC:  sel_byte = crc_inv[{idx_r[1:0], 3'b000} +: 8];
      default:  sel_byte = q_rdata.data;
    endcase

    crc_nxt = crc_r;
    if (step && src != SRC_CRC) begin
      crc_nxt = crc_byte(crc_start ? CRC_INIT : crc_r, sel_byte);
    end

    ov_nxt = ov_r;
    if (step) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign q_pop         = step && is_last;
  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_run_last  = orl_r;
  assign out_frame_end = ofe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FIRST;
      idx_r   <= '0;
      crc_r   <= CRC_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ob_r  <= sel_byte;
      orl_r <= is_last;
      ofe_r <= is_end;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ofe_r) |-> orl_r) else $error("frame end without run last");
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty) else $error("pop without queued item");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(ob_r)))
    else $error("output changed while stalled");
  a_crc_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (step && state_r == ST_DATA && q_rdata.closes) |=> (state_r == ST_CRC))
    else $error("trailer not started after last payload byte");

endmodule

[sv/transport_frame_crc_wrapper.sv]
// ----------------------------------------------------------------------------
// transport_frame_crc_wrapper
// Frames a payload byte stream: length/sequence header, CRC-32 trailer.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_data_byte, in_payload_length
//  out     | output    | out_valid, out_ready, out_byte, out_run_last, out_frame_end
//
//  one output byte per cycle unless the queue is empty or out_ready stalls:
//  each item gives its byte; an opener adds 8 header bytes, a closer 4 CRC bytes
//  a two-entry queue lets the front take items while a header or trailer runs
//  reset (rst_n low, synchronous) closes any open frame, zeroes the sequence
//  stalls on out_ready hold the output register; input stalls only on a full queue
// ----------------------------------------------------------------------------
module transport_frame_crc_wrapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [23:0] in_payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end
);
  import tfcw_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  tfcw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_payload_length (in_payload_length),
    .q_push            (q_push),
    .q_wdata           (q_wdata),
    .q_full            (q_full)
  );

  tfcw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  tfcw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives payload bytes into the transport framer and checks each output byte,
// its run_last and frame_end flags against a local framing and CRC-32 model.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;
  localparam logic [31:0] HDR_OVERHEAD = 32'd12;

  typedef struct packed {
    logic [7:0] b;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic [23:0] in_payload_length = 24'h000000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_frame_end;

  // framer model state
  logic [31:0] seq_num;
  logic [31:0] crc_acc;
  logic [23:0] bytes_left;

  framed_byte_t framed_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_bytes_checked = 0;
  int unsigned n_frames = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  transport_frame_crc_wrapper u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_payload_length(in_payload_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_REFLECTED_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic void push_framed(input logic [7:0] b, input logic hashed,
                                      input logic fend);
    framed_byte_t e;
    if (hashed) begin
      crc_acc = crc32_update(crc_acc, b);
    end
    e.b = b;
    e.run_last = 1'b0;
    e.frame_end = fend;
    framed_q.push_back(e);
  endfunction

  // expected output bytes for one accepted payload byte
  function automatic void frame_item(input logic [7:0] d, input logic [23:0] len_field);
    logic [23:0] len;
    logic [31:0] total;
    logic [31:0] crc_out;
    if (bytes_left == 24'h0) begin
      len = (len_field == 24'h0) ? 24'h1 : len_field;
      total = {8'h0, len} + HDR_OVERHEAD;
      crc_acc = CRC_SEED;
      for (int i = 0; i < 4; i++) begin
        push_framed(total[8*i +: 8], 1'b1, 1'b0);
      end
      for (int i = 0; i < 4; i++) begin
        push_framed(seq_num[8*i +: 8], 1'b1, 1'b0);
      end
      bytes_left = len;
    end
    push_framed(d, 1'b1, 1'b0);
    bytes_left = bytes_left - 24'h1;
    if (bytes_left == 24'h0) begin
      crc_out = ~crc_acc;
      for (int i = 0; i < 4; i++) begin
        push_framed(crc_out[8*i +: 8], 1'b0, i == 3);
      end
      seq_num = seq_num + 32'h1;
      crc_acc = CRC_SEED;
      n_frames++;
    end
    framed_q[framed_q.size() - 1].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // input monitor: predict on every accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      frame_item(in_data_byte, in_payload_length);
      n_items++;
    end
  end

  // output checker
  always @(posedge clk) begin : check_out
    framed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        report_mismatch("unexpected output byte", 32'(out_byte), 0);
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.b) report_mismatch("out_byte", 32'(out_byte), 32'(want.b));
        if (out_run_last !== want.run_last) begin
          report_mismatch("out_run_last", 32'(out_run_last), 32'(want.run_last));
        end
        if (out_frame_end !== want.frame_end) begin
          report_mismatch("out_frame_end", 32'(out_frame_end), 32'(want.frame_end));
        end
        n_bytes_checked++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [7:0] d, input logic [23:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_payload_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one frame; bytes after the first carry a random length that must be ignored
  task automatic send_frame(input logic [23:0] len, input int unsigned n_send);
    send_item(8'($urandom_range(255)), len);
    for (int unsigned i = 1; i < n_send; i++) begin
      send_item(8'($urandom_range(255)), 24'($urandom()));
    end
  endtask

  function automatic logic [23:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 24'h0;
    if (r < 70) return 24'($urandom_range(1, 6));
    if (r < 95) return 24'($urandom_range(7, 24));
    return 24'($urandom_range(25, 48));
  endfunction

  task automatic test_directed();
    // single-byte frame, all-zero data
    send_item(8'h00, 24'h000001);
    // zero length opens a one-byte frame
    send_item(8'hFF, 24'h000000);
    // two-byte frame; the length on the second byte is ignored
    send_item(8'h00, 24'h000002);
    send_item(8'hFF, 24'hFF_FFFF);
    send_item(8'hA5, 24'h000003);
    send_item(8'h5A, 24'h000000);
    send_item(8'h80, 24'h800000);
    send_item(8'h01, 24'h000001);
    release_input();
  endtask

  task automatic test_random_frames(input int unsigned n_target, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned start;
    logic [23:0] len;
    start = n_items;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (n_items - start < n_target) begin
      len = pick_length();
      send_frame(len, (len == 24'h0) ? 1 : 32'(len));
    end
    release_input();
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = HOLD_CYCLES;
    send_frame(24'd20, 20);
    send_frame(24'd1, 1);
    send_frame(24'd9, 9);
    release_input();
  endtask

  // maximum length frame; stays open, only its head is checked
  task automatic test_max_length_open();
    send_idle_pct = 17;
    recv_stall_pct = 17;
    send_frame(24'hFF_FFFF, 6);
    release_input();
  endtask

  initial begin
    seq_num = 32'h0;
    crc_acc = CRC_SEED;
    bytes_left = 24'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames(90, 0, 0);
    test_random_frames(70, 81, 0);
    test_random_frames(70, 0, 81);
    test_random_frames(90, 17, 17);
    test_output_holdoff();
    test_max_length_open();

    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d payload bytes, closed %0d frames, checked %0d output bytes",
             n_items, n_frames, n_bytes_checked);
    $display("covered zero and maximum lengths, idle/stall mixes and a long output hold-off");
    if (n_errors == 0 && framed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
